>>> src/bjse_pkg.sv
// Shared types, codes and helpers for the batch job schedule evaluator.
package bjse_pkg;

  localparam logic [23:0] TICK_MAX = 24'hFFFFFF;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 2'd1;

  // Scheduling policy codes.
  localparam logic [1:0] POL_FCFS  = 2'd0;
  localparam logic [1:0] POL_BURST = 2'd1;
  localparam logic [1:0] POL_PRIO  = 2'd2;
  localparam logic [1:0] POL_RR    = 2'd3;

  typedef struct packed {
    logic [15:0] arrival_tick;
    logic [15:0] burst_length;
    logic [7:0]  job_priority;
    logic        last_job;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  job_index;
    logic [23:0] finish_tick;
    logic [23:0] turnaround;
    logic [23:0] wait_total;
    logic        last_result;
  } out_item_t;

  // Static job record, written once per load.
  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
  } job_rec_t;

  // Run-time record, updated while the schedule is simulated.
  typedef struct packed {
    logic [15:0] remaining;
    logic [23:0] finish;
  } run_rec_t;

  typedef enum logic [2:0] {
    S_LOAD, S_RD, S_EV, S_PICK, S_ORD, S_OCALC, S_OWAIT
  } state_t;

  // Saturating addition on the 24-bit time scale.
  function automatic logic [23:0] sat_add(logic [23:0] a, logic [23:0] b);
    logic [24:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[24] ? TICK_MAX : s[23:0];
  endfunction

endpackage

>>> src/bjse_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module bjse_ram #(
  parameter int W     = 40,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/bjse_ctrl.sv
// Sequencer that loads jobs, simulates the schedule over the tables and emits results.
module bjse_ctrl #(
  parameter int MAX_JOBS = 16,
  parameter int AW       = 4,
  parameter int CW       = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bjse_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bjse_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [bjse_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                         cfg_data,
  output logic                                job_we,
  output logic [AW-1:0]                       job_waddr,
  output bjse_pkg::job_rec_t                  job_wdata,
  output logic                                run_we,
  output logic [AW-1:0]                       run_waddr,
  output bjse_pkg::run_rec_t                  run_wdata,
  output logic [AW-1:0]                       rd_addr,
  input  bjse_pkg::job_rec_t                  job_rdata,
  input  bjse_pkg::run_rec_t                  run_rdata
);
  import bjse_pkg::*;

  state_t state, state_next;
  logic [1:0]  policy;
  logic [15:0] quantum;
  logic [CW-1:0] count, n, left;
  logic [AW-1:0] idx, best_idx;
  logic [23:0] clock, earliest;
  logic [MAX_JOBS-1:0] done;
  logic best_valid, ran;
  logic [15:0] best_burst, best_arr;
  logic [7:0]  best_prio;

  logic idx_last, elig, better, take, pend, rr_fin, ran_upd, load_last, out_xfer;
  logic [15:0] q, slice, rr_rem;
  logic [23:0] arr24, base, fc_clock, rr_clock, earliest_upd, pick_clock;
  logic [23:0] ta, wt;
  logic [AW+3:0] idx_wide;

  // Per-entry evaluation of the record currently read from the tables.
  always_comb begin
    idx_last  = (CW'(idx) == n - CW'(1));
    load_last = in_data.last_job || (count == CW'(MAX_JOBS - 1));
    out_xfer  = out_valid && !out_stall;
    q         = (quantum == 16'd0) ? 16'd1 : quantum;
    arr24     = {8'd0, job_rdata.arrival};
    base      = (clock < arr24) ? arr24 : clock;
    fc_clock  = sat_add(base, {8'd0, job_rdata.burst});
    slice     = (run_rdata.remaining < q) ? run_rdata.remaining : q;
    rr_clock  = sat_add(clock, {8'd0, slice});
    rr_rem    = run_rdata.remaining - slice;
    elig      = !done[idx] && (arr24 <= clock);
    if (policy == POL_BURST) begin
      better = (job_rdata.burst < best_burst) ||
               ((job_rdata.burst == best_burst) && (job_rdata.arrival < best_arr));
    end else begin
      better = job_rdata.prio < best_prio;
    end
    take         = elig && (!best_valid || better);
    pend         = !done[idx] && (arr24 < earliest);
    earliest_upd = pend ? arr24 : earliest;
    rr_fin       = elig && (rr_rem == 16'd0);
    ran_upd      = ran || elig;
    pick_clock   = sat_add(clock, {8'd0, best_burst});
    ta = (run_rdata.finish >= arr24) ? run_rdata.finish - arr24 : 24'd0;
    wt = (ta >= {8'd0, job_rdata.burst}) ? ta - {8'd0, job_rdata.burst} : 24'd0;
    idx_wide = {4'd0, idx};
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:  if (in_valid && load_last) state_next = S_RD;
      S_RD:    state_next = S_EV;
      S_EV: begin
        if (!idx_last) begin
          state_next = S_RD;
        end else begin
          case (policy)
            POL_FCFS:  state_next = S_ORD;
            POL_BURST: state_next = S_PICK;
            POL_PRIO:  state_next = S_PICK;
            default:   state_next = ((left - CW'(rr_fin)) == '0) ? S_ORD : S_RD;
          endcase
        end
      end
      S_PICK:  state_next = (best_valid && left == CW'(1)) ? S_ORD : S_RD;
      S_ORD:   state_next = S_OCALC;
      S_OCALC: state_next = S_OWAIT;
      S_OWAIT: if (out_xfer) state_next = idx_last ? S_LOAD : S_ORD;
      default: state_next = S_LOAD;
    endcase
  end

  // Table ports and handshake outputs.
  always_comb begin
    in_stall  = (state != S_LOAD);
    rd_addr   = idx;
    job_we    = (state == S_LOAD) && in_valid;
    job_waddr = count[AW-1:0];
    job_wdata = '{arrival: in_data.arrival_tick, burst: in_data.burst_length,
                  prio: in_data.job_priority};
    run_we    = 1'b0;
    run_waddr = idx;
    run_wdata = '{remaining: run_rdata.remaining, finish: fc_clock};
    case (state)
      S_LOAD: begin
        run_we    = in_valid;
        run_waddr = count[AW-1:0];
        run_wdata = '{remaining: in_data.burst_length, finish: 24'd0};
      end
      S_EV: begin
        if (policy == POL_FCFS) begin
          run_we = 1'b1;
        end else if (policy == POL_RR) begin
          run_we    = elig;
          run_wdata = '{remaining: rr_rem, finish: rr_clock};
        end
      end
      S_PICK: begin
        run_we    = best_valid;
        run_waddr = best_idx;
        run_wdata = '{remaining: 16'd0, finish: pick_clock};
      end
      default: run_we = 1'b0;
    endcase
  end

  // Registers of the sequencer and the output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      policy     <= POL_FCFS;
      quantum    <= 16'd4;
      count      <= '0;
      n          <= '0;
      left       <= '0;
      idx        <= '0;
      clock      <= '0;
      done       <= '0;
      best_valid <= 1'b0;
      ran        <= 1'b0;
      earliest   <= TICK_MAX;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == CFG_POLICY) policy <= cfg_data[1:0];
        else if (cfg_index == CFG_QUANTUM) quantum <= cfg_data;
      end
      case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (load_last) begin
              count      <= '0;
              n          <= count + CW'(1);
              left       <= count + CW'(1);
              clock      <= '0;
              done       <= '0;
              idx        <= '0;
              best_valid <= 1'b0;
              ran        <= 1'b0;
              earliest   <= TICK_MAX;
            end else begin
              count <= count + CW'(1);
            end
          end
        end
        S_EV: begin
          case (policy)
            POL_FCFS: begin
              clock     <= fc_clock;
              done[idx] <= 1'b1;
              left      <= left - CW'(1);
            end
            POL_BURST, POL_PRIO: begin
              earliest <= earliest_upd;
              if (take) begin
                best_valid <= 1'b1;
                best_idx   <= idx;
                best_burst <= job_rdata.burst;
                best_arr   <= job_rdata.arrival;
                best_prio  <= job_rdata.prio;
              end
            end
            default: begin
              // Round robin: run a slice of each eligible job; at the end of a pass, idle jump when nothing ran.
              earliest <= idx_last ? TICK_MAX : earliest_upd;
              ran      <= idx_last ? 1'b0 : ran_upd;
              if (elig) clock <= rr_clock;
              else if (idx_last && !ran_upd) clock <= earliest_upd;
              if (rr_fin) begin
                done[idx] <= 1'b1;
                left      <= left - CW'(1);
              end
            end
          endcase
          idx <= idx_last ? '0 : idx + AW'(1);
        end
        S_PICK: begin
          if (best_valid) begin
            clock          <= pick_clock;
            done[best_idx] <= 1'b1;
            left           <= left - CW'(1);
          end else begin
            clock <= earliest;
          end
          best_valid <= 1'b0;
          earliest   <= TICK_MAX;
        end
        S_OCALC: begin
          out_valid <= 1'b1;
          out_data  <= '{job_index: idx_wide[3:0], finish_tick: run_rdata.finish,
                         turnaround: ta, wait_total: wt, last_result: idx_last};
        end
        S_OWAIT: begin
          if (out_xfer) begin
            out_valid <= 1'b0;
            idx       <= idx_last ? '0 : idx + AW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The result is valid only while waiting for its transfer.
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OWAIT) else $error("result valid outside output wait");

  // Jobs left to finish never exceed the set size.
  a_left_bound: assert property (@(posedge clk) disable iff (rst)
    left <= n) else $error("left count exceeds job count");

  // Every job of the set is finished once results start.
  a_all_done: assert property (@(posedge clk) disable iff (rst)
    state == S_ORD |-> $countones(done) == int'(n)) else $error("results before all jobs done");

  // The transfer of the final result returns the block to loading.
  a_last_back: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_data.last_result) |=> state == S_LOAD)
    else $error("no return to loading after final result");

endmodule

>>> src/batch_job_schedule_evaluator_top.sv
// Loading: each accepted input writes one job record; the final job starts the simulation.
// Simulation: each pass reads (S_RD) then evaluates (S_EV) every job; FCFS makes one pass,
// shortest burst and priority a pass and S_PICK per pick or idle jump, round robin passes
// until all finish. Results: in load order, each held until taken, then loading resumes.
// Reset (rst, synchronous) empties the job set, selects FCFS and sets the quantum to 4.
module batch_job_schedule_evaluator_top #(
  parameter int MAX_JOBS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bjse_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bjse_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [bjse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);
  import bjse_pkg::*;

  localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW = $clog2(MAX_JOBS + 1);

  logic          job_we, run_we;
  logic [AW-1:0] job_waddr, run_waddr, rd_addr;
  job_rec_t      job_wdata, job_rdata;
  run_rec_t      run_wdata, run_rdata;

  // Static job records.
  bjse_ram #(.W($bits(job_rec_t)), .DEPTH(MAX_JOBS), .AW(AW)) u_job_ram (
    .clk(clk), .we(job_we), .waddr(job_waddr), .wdata(job_wdata),
    .raddr(rd_addr), .rdata(job_rdata)
  );

  // Remaining time and finish time per job.
  bjse_ram #(.W($bits(run_rec_t)), .DEPTH(MAX_JOBS), .AW(AW)) u_run_ram (
    .clk(clk), .we(run_we), .waddr(run_waddr), .wdata(run_wdata),
    .raddr(rd_addr), .rdata(run_rdata)
  );

  // Sequencer.
  bjse_ctrl #(.MAX_JOBS(MAX_JOBS), .AW(AW), .CW(CW)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .job_we(job_we), .job_waddr(job_waddr), .job_wdata(job_wdata),
    .run_we(run_we), .run_waddr(run_waddr), .run_wdata(run_wdata),
    .rd_addr(rd_addr), .job_rdata(job_rdata), .run_rdata(run_rdata)
  );

endmodule
